[rtl/ccov_pkg.sv]
// shared types, constants and helpers for the per-cluster covariance block
package ccov_pkg;

    localparam int DIMS        = 4;
    localparam int CLUSTERS    = 8;
    localparam int COORD_WIDTH = 16;

    localparam int CL_W    = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
    localparam int DIM_W   = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam int D_W     = $clog2(DIMS + 1);
    localparam int STEP_W  = $clog2(DIMS + 1);
    localparam int ADDR_W  = $clog2(CLUSTERS * DIMS) > 0 ? $clog2(CLUSTERS * DIMS) : 1;
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SUM_W   = 56;
    localparam int CNT_W   = 16;
    localparam int DCNT_W  = $clog2(SUM_W + 1);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ACC  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_RD_ADDR,
        S_RD_DATA,
        S_DIV,
        S_OUT
    } state_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [SUM_W-1:0]       sum_t;

    typedef struct packed {
        logic [1:0]   operation;
        logic [2:0]   cluster;
        logic signed [15:0] coord_0;
        logic signed [15:0] coord_1;
        logic signed [15:0] coord_2;
        logic signed [15:0] coord_3;
    } in_item_t;

    typedef struct packed {
        logic [2:0]          out_cluster;
        logic [1:0]          row;
        logic [1:0]          column;
        logic signed [55:0]  covariance;
        logic                valid_res;
        logic                last;
    } out_item_t;

    // control handed from the sequencer to every lane
    typedef struct packed {
        logic              load_center;
        logic              capture_diff;
        logic              acc_step;
        logic [CL_W-1:0]   cl;
        logic [DIM_W-1:0]  col;
        logic [D_W-1:0]    dims;
        logic              live;
    } lane_ctl_t;

    function automatic coord_t coord_of(in_item_t it, int unsigned idx);
        coord_t c;
        c = '0;
        case (idx)
            0: c = it.coord_0;
            1: c = it.coord_1;
            2: c = it.coord_2;
            3: c = it.coord_3;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

[rtl/per_cluster_covariance_top.sv]
// per-cluster covariance: lanes per triangle row, sequencer and readout merge
// load center: next transaction accepted the following cycle
// accumulate: all row lanes multiply-accumulate in parallel
// readout: per triangle entry the address and data states, then the shared
// one-bit-per-cycle divider (skipped with fewer than two samples), then the output state, which waits on output stalls
// reset clears centers, sums (through zero counts) and counts; dims_reg resets to 4
module per_cluster_covariance_top
    import ccov_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [2:0] cfg_wdata,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    state_t state_reg, state_next;

    logic [2:0]        dims_reg;
    logic [D_W-1:0]    d_eff;
    logic [CNT_W-1:0]  count_reg [CLUSTERS];
    logic [CL_W-1:0]   cl_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DIM_W-1:0]  rh_reg;
    logic [DIM_W-1:0]  rj_reg;
    sum_t              res_reg;
    logic              resv_reg;
    logic              out_valid_reg;
    out_item_t         out_reg;

    logic       accept;
    logic       out_free;
    logic       entry_last;
    logic [CNT_W-1:0] cnt_cur;
    lane_ctl_t  ctl;
    logic       div_start;
    logic       div_done;
    sum_t       div_q;
    sum_t       sum_sel;

    coord_t x_vec    [DIMS];
    diff_t  diff_vec [DIMS];
    sum_t   rdata_vec[DIMS];

    assign d_eff = (dims_reg == 3'd0) ? D_W'(1) :
                   ((D_W+1)'(dims_reg) > (D_W+1)'(DIMS)) ? D_W'(DIMS) : D_W'(dims_reg);

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign cnt_cur  = count_reg[cl_reg];
    assign sum_sel  = (cnt_cur != '0) ? rdata_vec[rh_reg] : '0;
    assign entry_last = (D_W'(rh_reg) == d_eff - 1'b1) && (D_W'(rj_reg) == d_eff - 1'b1);

    genvar g;
    generate
        for (g = 0; g < DIMS; g++)
        begin : g_lane
            assign x_vec[g] = coord_of(in_data, g);
            ccov_lane u_lane (
                .clk      (clk),
                .rst_n    (rst_n),
                .lane_idx (DIM_W'(g)),
                .ctl      (ctl),
                .x        (x_vec[g]),
                .diff_all (diff_vec),
                .diff     (diff_vec[g]),
                .rdata    (rdata_vec[g])
            );
        end
    endgenerate

    ccov_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_sel),
        .divisor  (cnt_cur - 1'b1),
        .done     (div_done),
        .quotient (div_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_data.operation == OP_ACC
                    && count_reg[in_data.cluster] != CNT_MAX)
                begin
                    state_next = S_ACC;
                end
                else if (accept && in_data.operation == OP_READ)
                begin
                    state_next = S_RD_ADDR;
                end
            end
            S_ACC:
            begin
                if (step_reg == STEP_W'(DIMS))
                begin
                    state_next = S_IDLE;
                end
            end
            S_RD_ADDR: state_next = S_RD_DATA;
            S_RD_DATA: state_next = (cnt_cur >= CNT_W'(2)) ? S_DIV : S_OUT;
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = entry_last ? S_IDLE : S_RD_ADDR;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall         = 1'b1;
        div_start        = 1'b0;
        ctl.load_center  = 1'b0;
        ctl.capture_diff = 1'b0;
        ctl.acc_step     = 1'b0;
        ctl.cl           = cl_reg;
        ctl.col          = rj_reg;
        ctl.dims         = d_eff;
        ctl.live         = (cnt_cur != '0);
        case (state_reg)
            S_IDLE:
            begin
                in_stall         = 1'b0;
                ctl.cl           = in_data.cluster;
                ctl.load_center  = accept && in_data.operation == OP_LOAD;
                ctl.capture_diff = accept && in_data.operation == OP_ACC;
            end
            S_ACC:
            begin
                ctl.col      = DIM_W'(step_reg);
                ctl.acc_step = (step_reg < STEP_W'(DIMS));
            end
            S_RD_DATA:
            begin
                div_start = (cnt_cur >= CNT_W'(2));
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dims_reg      <= 3'd4;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            rh_reg        <= '0;
            rj_reg        <= '0;
            for (int i = 0; i < CLUSTERS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                dims_reg <= cfg_wdata;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    step_reg <= '0;
                    rh_reg   <= '0;
                    rj_reg   <= '0;
                end
                S_ACC:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(DIMS))
                    begin
                        count_reg[cl_reg] <= cnt_cur + 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (entry_last)
                        begin
                            count_reg[cl_reg] <= '0;
                        end
                        else if (D_W'(rj_reg) + 1'b1 < d_eff)
                        begin
                            rj_reg <= rj_reg + 1'b1;
                        end
                        else
                        begin
                            rh_reg <= rh_reg + 1'b1;
                            rj_reg <= rh_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    step_reg <= step_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cl_reg <= in_data.cluster;
        end
        if (state_reg == S_RD_DATA)
        begin
            res_reg  <= '0;
            resv_reg <= (cnt_cur >= CNT_W'(2));
        end
        else if (state_reg == S_DIV && div_done)
        begin
            res_reg <= div_q;
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_reg.out_cluster <= 3'(cl_reg);
            out_reg.row         <= 2'(rh_reg);
            out_reg.column      <= 2'(rj_reg);
            out_reg.covariance  <= res_reg;
            out_reg.valid_res   <= resv_reg;
            out_reg.last        <= entry_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

[rtl/ccov_lane.sv]
// one lane: centers and product sums for one triangle row
module ccov_lane
    import ccov_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [DIM_W-1:0] lane_idx,
    input  lane_ctl_t        ctl,
    input  coord_t           x,
    input  diff_t            diff_all [DIMS],
    output diff_t            diff,
    output sum_t             rdata
);

    coord_t center_reg [CLUSTERS];
    diff_t  diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic   wen_reg;
    logic   act_reg;
    logic [DIM_W-1:0] wcol_reg;
    sum_t   rdata_reg;
    sum_t   mem [CLUSTERS * DIMS];

    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic              step_en;
    sum_t              base;
    logic signed [PROD_W-1:0] prod_eff;
    logic signed [SUM_W:0] s_wide;
    sum_t              s_sat;

    assign raddr = ADDR_W'(ctl.cl) * ADDR_W'(DIMS) + ADDR_W'(ctl.col);
    assign waddr = ADDR_W'(ctl.cl) * ADDR_W'(DIMS) + ADDR_W'(wcol_reg);

    // columns from the diagonal up to the active dimension count; the first
    // sample of a cluster also zeroes the inactive columns
    assign step_en = ctl.acc_step && (ctl.col >= lane_idx)
                     && ((D_W'(ctl.col) < ctl.dims) || !ctl.live);

    assign base     = ctl.live ? rdata_reg : '0;
    assign prod_eff = act_reg ? prod_reg : '0;
    assign s_wide   = (SUM_W+1)'(base) + (SUM_W+1)'(prod_eff);

    always_comb
    begin
        if (s_wide[SUM_W] != s_wide[SUM_W-1])
        begin
            s_sat = s_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            s_sat = s_wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CLUSTERS; i++)
            begin
                center_reg[i] <= '0;
            end
            wen_reg <= 1'b0;
        end
        else
        begin
            if (ctl.load_center)
            begin
                center_reg[ctl.cl] <= x;
            end
            wen_reg <= step_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture_diff)
        begin
            diff_reg <= DIFF_W'(x) - DIFF_W'(center_reg[ctl.cl]);
        end
        prod_reg  <= diff_reg * diff_all[ctl.col];
        act_reg   <= (D_W'(ctl.col) < ctl.dims);
        wcol_reg  <= ctl.col;
        rdata_reg <= mem[raddr];
        if (wen_reg)
        begin
            mem[waddr] <= s_sat;
        end
    end

    assign diff  = diff_reg;
    assign rdata = rdata_reg;

endmodule

[rtl/ccov_div.sv]
// iterative signed-by-unsigned divider, one quotient bit per cycle
module ccov_div
    import ccov_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  sum_t             dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output sum_t             quotient
);

    logic [SUM_W-1:0]  mag_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  div_reg;
    logic              neg_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [CNT_W:0] shifted;
    logic [CNT_W:0] trial;

    assign shifted = {rem_reg, mag_reg[SUM_W-1]};
    assign trial   = shifted - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[SUM_W-1];
            mag_reg <= dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[CNT_W])
            begin
                rem_reg <= trial[CNT_W-1:0];
                mag_reg <= {mag_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[CNT_W-1:0];
                mag_reg <= {mag_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? SUM_W'(-mag_reg) : mag_reg;

endmodule

[rtl/ccov_checker.sv]
// port-level checks for the covariance block, bound to the top level
module ccov_checker
    import ccov_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result transaction changed");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.valid_res |-> out_data.covariance == '0)
        else $error("entry without enough samples carries a value");

    a_upper_tri: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.column >= out_data.row)
        else $error("entry below the diagonal");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.last |=> !out_valid)
        else $error("result transaction right after end of readout");

endmodule

bind per_cluster_covariance_top ccov_checker u_ccov_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

[test/tb_per_cluster_covariance_top.sv]
// testbench for the per-cluster covariance block: directed and random transactions
`timescale 1ns / 100ps

module tb_per_cluster_covariance_top;
    import ccov_pkg::*;

    localparam int TRI_N        = DIMS * (DIMS + 1) / 2;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int SETTLE       = 100;
    localparam int COUNT_TOP    = 65535;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [2:0] cfg_wdata;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    per_cluster_covariance_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // shadow state of the block
    longint    center_mirror [CLUSTERS][DIMS];
    longint    sum_mirror    [CLUSTERS][TRI_N];
    int        count_mirror  [CLUSTERS];
    logic [2:0] dims_mirror;

    out_item_t entry_queue[$];
    int        error_count;
    int        cycle_count;

    // sender and receiver pacing
    int        burst_left;
    bit        sender_gaps;
    int        stall_pct;
    logic      hold_active;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("per_cluster_covariance_top test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= hold_active || ($urandom_range(99) < stall_pct);
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // check every result transaction against the oldest expected entry
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (entry_queue.size() == 0)
                report_mismatch($sformatf("unexpected entry %p", out_data));
            else
            begin
                want = entry_queue.pop_front();
                if (out_data.out_cluster !== want.out_cluster)
                    report_mismatch($sformatf("cluster %0d want %0d",
                        out_data.out_cluster, want.out_cluster));
                if (out_data.row !== want.row)
                    report_mismatch($sformatf("row %0d want %0d", out_data.row, want.row));
                if (out_data.column !== want.column)
                    report_mismatch($sformatf("column %0d want %0d",
                        out_data.column, want.column));
                if (out_data.covariance !== want.covariance)
                    report_mismatch($sformatf("covariance %0d want %0d (cl %0d %0d,%0d)",
                        out_data.covariance, want.covariance, want.out_cluster,
                        want.row, want.column));
                if (out_data.valid_res !== want.valid_res)
                    report_mismatch($sformatf("valid_res %0b want %0b",
                        out_data.valid_res, want.valid_res));
                if (out_data.last !== want.last)
                    report_mismatch($sformatf("last %0b want %0b", out_data.last, want.last));
            end
        end
    end

    function automatic int dims_effective();
        int d;
        d = dims_mirror;
        if (d == 0)
            d = 1;
        if (d > DIMS)
            d = DIMS;
        return d;
    endfunction

    // update shadow state for one accepted transaction and queue its entries
    function automatic void covariance_update(in_item_t it);
        longint    x[DIMS];
        longint    s;
        int        d;
        int        t;
        int        n;
        int        total;
        int        cl;
        int        c;
        out_item_t e;
        d = dims_effective();
        cl = it.cluster;
        x[0] = longint'(it.coord_0);
        x[1] = longint'(it.coord_1);
        x[2] = longint'(it.coord_2);
        x[3] = longint'(it.coord_3);
        case (op_t'(it.operation))
            OP_LOAD:
                for (int h = 0; h < DIMS; h++)
                    center_mirror[cl][h] = x[h];
            OP_ACC:
                if (count_mirror[cl] < COUNT_TOP)
                begin
                    t = 0;
                    for (int h = 0; h < DIMS; h++)
                        for (int j = h; j < DIMS; j++)
                        begin
                            if (h < d && j < d)
                            begin
                                s = sum_mirror[cl][t] + (x[h] - center_mirror[cl][h]) *
                                    (x[j] - center_mirror[cl][j]);
                                if (s > longint'(SUM_MAX))
                                    s = SUM_MAX;
                                if (s < longint'(SUM_MIN))
                                    s = SUM_MIN;
                                sum_mirror[cl][t] = s;
                            end
                            t++;
                        end
                    count_mirror[cl]++;
                end
            OP_READ:
            begin
                c = count_mirror[cl];
                total = d * (d + 1) / 2;
                t = 0;
                n = 0;
                for (int h = 0; h < DIMS; h++)
                    for (int j = h; j < DIMS; j++)
                    begin
                        if (h < d && j < d)
                        begin
                            e.out_cluster = 3'(cl);
                            e.row = 2'(h);
                            e.column = 2'(j);
                            e.covariance = (c >= 2) ?
                                56'(sum_mirror[cl][t] / longint'(c - 1)) : 56'(0);
                            e.valid_res = (c >= 2);
                            e.last = (n + 1 == total);
                            entry_queue.push_back(e);
                            n++;
                        end
                        t++;
                    end
                for (int k = 0; k < TRI_N; k++)
                    sum_mirror[cl][k] = 0;
                count_mirror[cl] = 0;
            end
            default: ;
        endcase
    endfunction

    // drive one transaction, wait for acceptance, then maybe open a gap
    task automatic send_item(input in_item_t it);
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (in_stall);
        covariance_update(it);
        if (sender_gaps)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(8, 1)) @(posedge clk);
                burst_left = $urandom_range(12, 1);
            end
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (entry_queue.size() != 0)
            @(posedge clk);
        // an accumulate may still be in flight with nothing to show for it
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_dims(input logic [2:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        dims_mirror = value;
        @(posedge clk);
    endtask

    function automatic coord_t pick_coord();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return coord_t'($urandom_range(511)) - 16'sd256;
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic in_item_t make_item(op_t op, int cl);
        in_item_t it;
        it.operation = op;
        it.cluster = 3'(cl);
        it.coord_0 = pick_coord();
        it.coord_1 = pick_coord();
        it.coord_2 = pick_coord();
        it.coord_3 = pick_coord();
        return it;
    endfunction

    function automatic in_item_t make_flat(op_t op, int cl, coord_t v);
        in_item_t it;
        it.operation = op;
        it.cluster = 3'(cl);
        it.coord_0 = v;
        it.coord_1 = v;
        it.coord_2 = v;
        it.coord_3 = v;
        return it;
    endfunction

    // mostly accumulate, with some loads, readouts and no-op transactions
    function automatic in_item_t random_item();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return make_item(OP_LOAD, $urandom_range(CLUSTERS - 1));
        if (r < 80)
            return make_item(OP_ACC, $urandom_range(CLUSTERS - 1));
        if (r < 95)
            return make_item(OP_READ, $urandom_range(CLUSTERS - 1));
        return make_item(OP_NONE, $urandom_range(CLUSTERS - 1));
    endfunction

    task automatic test_empty_after_reset();
        send_item(make_item(OP_READ, 3));
        send_item(make_item(OP_READ, 7));
    endtask

    task automatic test_directed_extremes();
        // one sample only, then three extreme samples against extreme centers
        send_item(make_flat(OP_ACC, 1, 16'sh0100));
        send_item(make_item(OP_READ, 1));
        send_item(make_flat(OP_LOAD, 0, 16'sh8000));
        send_item(make_flat(OP_ACC, 0, 16'sh7fff));
        send_item(make_flat(OP_ACC, 0, 16'sh8000));
        send_item(make_flat(OP_ACC, 0, 16'sh7fff));
        send_item(make_item(OP_NONE, 0));
        send_item(make_item(OP_READ, 0));
        // readout keeps the center, so the next sums start from it again
        send_item(make_flat(OP_ACC, 0, 16'sh0000));
        send_item(make_flat(OP_ACC, 0, 16'shffff));
        send_item(make_item(OP_READ, 0));
        send_item(make_flat(OP_LOAD, 5, 16'sh7fff));
        send_item(make_item(OP_ACC, 5));
        send_item(make_item(OP_ACC, 5));
        send_item(make_item(OP_ACC, 5));
        send_item(make_item(OP_LOAD, 5));
        send_item(make_item(OP_ACC, 5));
        send_item(make_item(OP_READ, 5));
        send_item(make_item(OP_READ, 5));
    endtask

    // samples gathered under one dimension count may be read under another
    task automatic test_dims_settings();
        logic [2:0] plan[6];
        plan = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd7, 3'd5};
        foreach (plan[p])
        begin
            write_dims(plan[p]);
            stall_pct = (p % 3 == 0) ? 0 : 10 * p;
            sender_gaps = (p != 2);
            repeat (8) send_item(random_item());
            send_item(make_item(OP_READ, p % CLUSTERS));
        end
        write_dims(3'd6);
        write_dims(3'd4);
    endtask

    task automatic test_backpressure();
        wait_drained();
        stall_pct = 30;
        hold_active <= 1'b1;
        fork
            begin
                repeat (2000) @(posedge clk);
                hold_active <= 1'b0;
            end
        join_none
        for (int k = 0; k < 6; k++)
        begin
            send_item(make_item(OP_ACC, k % 3));
            send_item(make_item(OP_ACC, k % 3));
            send_item(make_item(OP_READ, k % 3));
        end
        wait_drained();
        stall_pct = 20;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 3'd0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        hold_active = 1'b0;
        stall_pct = 25;
        sender_gaps = 1'b1;
        burst_left = 4;
        error_count = 0;
        cycle_count = 0;
        dims_mirror = 3'd4;
        for (int c = 0; c < CLUSTERS; c++)
        begin
            count_mirror[c] = 0;
            for (int h = 0; h < DIMS; h++)
                center_mirror[c][h] = 0;
            for (int t = 0; t < TRI_N; t++)
                sum_mirror[c][t] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_after_reset();
        test_directed_extremes();
        test_dims_settings();
        test_backpressure();

        wait_drained();
        if (error_count == 0)
            $display("per_cluster_covariance_top test passed");
        else
            $display("per_cluster_covariance_top test failed");
        $finish;
    end

endmodule
